// ----- src/ecfm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ecfm_pkg
// Shared constants, widths and the arctangent table for the equirectangular
// cube-face coordinate map.
// ----------------------------------------------------------------------------
package ecfm_pkg;

	localparam int MAX_DIMENSION_DEF = 4096;
	localparam int FRAC_BITS_DEF     = 8;
	localparam int CORDIC_STEPS_DEF  = 16;

	localparam int TAB_LEN  = 24;
	localparam int IN_SCALE = 16;
	localparam int ZW       = 32;
	localparam int X1W      = 32;
	localparam int X2W      = 44;

	localparam logic [29:0] KINV_Q30 = 30'd652032874;

	localparam int FACE_W = 11;
	localparam int SRC_W  = 13;
	localparam int IDX_W  = 10;
	localparam int OUT_W  = 20;
	localparam int CFG_IW = 2;

	localparam logic [CFG_IW-1:0] CFG_FACE_WIDTH    = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_FACE_HEIGHT   = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_SOURCE_WIDTH  = 2'd2;
	localparam logic [CFG_IW-1:0] CFG_SOURCE_HEIGHT = 2'd3;

	// atan(2^-i) in units of pi * 2^-30
	function automatic logic [ZW-1:0] atan_entry(input int i);
		logic [ZW-1:0] r;
		case (i)
			0: r = 32'd268435456;
			1: r = 32'd158466703;
			2: r = 32'd83729454;
			3: r = 32'd42502378;
			4: r = 32'd21333666;
			5: r = 32'd10677233;
			6: r = 32'd5339919;
			7: r = 32'd2670123;
			8: r = 32'd1335082;
			9: r = 32'd667543;
			10: r = 32'd333772;
			11: r = 32'd166886;
			12: r = 32'd83443;
			13: r = 32'd41722;
			14: r = 32'd20861;
			15: r = 32'd10430;
			16: r = 32'd5215;
			17: r = 32'd2608;
			18: r = 32'd1304;
			19: r = 32'd652;
			20: r = 32'd326;
			21: r = 32'd163;
			22: r = 32'd81;
			23: r = 32'd41;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- src/ecfm_cordic_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ecfm_cordic_cell
// One vectoring CORDIC iteration, registered, with a pass-along payload.
// ----------------------------------------------------------------------------
module ecfm_cordic_cell
	import ecfm_pkg::*;
#(
	parameter int XW   = 32,
	parameter int PW   = 8,
	parameter int STEP = 0
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 prev_valid,
	input  wire logic signed [XW-1:0] prev_x,
	input  wire logic signed [XW-1:0] prev_y,
	input  wire logic signed [ZW-1:0] prev_z,
	input  wire logic [PW-1:0]        prev_pay,
	output logic                      next_valid,
	output logic signed [XW-1:0]      next_x,
	output logic signed [XW-1:0]      next_y,
	output logic signed [ZW-1:0]      next_z,
	output logic [PW-1:0]             next_pay
);

	localparam logic signed [ZW-1:0] ATAN = atan_entry(STEP);

	logic signed [XW-1:0] xs, ys;

	assign xs = prev_x >>> STEP;
	assign ys = prev_y >>> STEP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_valid <= 1'b0;
		end else if (en) begin
			next_valid <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			next_pay <= prev_pay;
			if (!prev_y[XW-1]) begin
				next_x <= prev_x + ys;
				next_y <= prev_y - xs;
				next_z <= prev_z + ATAN;
			end else begin
				next_x <= prev_x - ys;
				next_y <= prev_y + xs;
				next_z <= prev_z - ATAN;
			end
		end
	end

endmodule
`default_nettype wire

// ----- src/equirect_cube_face_coord_map_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// equirect_cube_face_coord_map_core
// Maps a front cube-face pixel to fractional equirectangular source
// coordinates through two chains of pipelined CORDIC cells.
// ----------------------------------------------------------------------------
// channel | signals                               | transfer when
// in      | in_valid, in_ready, face_row/col      | in_valid & in_ready
// out     | out_valid, out_ready, source_x/y      | out_valid & out_ready
// cfg     | cfg_valid, cfg_ready, cfg_index/data  | cfg_valid & cfg_ready
//
// One item per cycle while the output is not stalled. Items pass through the
// input stage, both CORDIC cell chains and the gain, scale and output stages.
// The whole pipeline stalls only while the output register holds a result
// that is not taken. Reset clears all valid bits and loads default config.
// ----------------------------------------------------------------------------
module equirect_cube_face_coord_map_core
	import ecfm_pkg::*;
#(
	parameter int MAX_DIMENSION = MAX_DIMENSION_DEF,
	parameter int FRAC_BITS     = FRAC_BITS_DEF,
	parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [IDX_W-1:0]  face_row,
	input  wire logic [IDX_W-1:0]  face_col,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [OUT_W-1:0]       source_x,
	output logic [OUT_W-1:0]       source_y,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [SRC_W-1:0]  cfg_data
);

	localparam int N   = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
	localparam int SHX = 31 - FRAC_BITS;
	localparam int SHY = 30 - FRAC_BITS;
	localparam logic [63:0] LIM = 64'(MAX_DIMENSION - 1) << FRAC_BITS;
	localparam int PW1 = 23 + FACE_W;

	logic [FACE_W-1:0] fw_q, fh_q;
	logic [SRC_W-1:0]  sw_q, sh_q;
	logic              en;

	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= 11'd512;
			fh_q <= 11'd512;
			sw_q <= 13'd3840;
			sh_q <= 13'd1920;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FACE_WIDTH:    fw_q <= cfg_data[FACE_W-1:0];
				CFG_FACE_HEIGHT:   fh_q <= cfg_data[FACE_W-1:0];
				CFG_SOURCE_WIDTH:  sw_q <= cfg_data;
				CFG_SOURCE_HEIGHT: sh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: normalize inputs
	logic [FACE_W-1:0] w, h;
	logic signed [FACE_W:0] d, b;
	assign w = (fw_q == '0) ? FACE_W'(1) : fw_q;
	assign h = (fh_q == '0) ? FACE_W'(1) : fh_q;
	assign d = $signed({1'b0, face_col, 1'b0}) - $signed({1'b0, w});
	assign b = $signed({1'b0, face_row, 1'b0}) - $signed({1'b0, h});

	logic                    v_s1;
	logic [FACE_W-1:0]       w_s1, h_s1;
	logic signed [FACE_W:0]  d_s1;
	logic signed [22:0]      bw_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1  <= w;
			h_s1  <= h;
			d_s1  <= d;
			bw_s1 <= 23'(b) * 23'($signed({1'b0, w}));
		end
	end

	// first CORDIC chain: u = atan2(d, w)
	logic                  c1v [0:N];
	logic signed [X1W-1:0] c1x [0:N];
	logic signed [X1W-1:0] c1y [0:N];
	logic signed [ZW-1:0]  c1z [0:N];
	logic [PW1-1:0]        c1p [0:N];

	assign c1v[0] = v_s1;
	assign c1x[0] = X1W'({w_s1, {IN_SCALE{1'b0}}});
	assign c1y[0] = X1W'($signed({d_s1, {IN_SCALE{1'b0}}}));
	assign c1z[0] = '0;
	assign c1p[0] = {bw_s1, h_s1};

	for (genvar i = 0; i < N; i++) begin : g_c1
		ecfm_cordic_cell #(.XW(X1W), .PW(PW1), .STEP(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.prev_valid(c1v[i]), .prev_x(c1x[i]), .prev_y(c1y[i]),
			.prev_z(c1z[i]), .prev_pay(c1p[i]),
			.next_valid(c1v[i+1]), .next_x(c1x[i+1]), .next_y(c1y[i+1]),
			.next_z(c1z[i+1]), .next_pay(c1p[i+1])
		);
	end

	// gain correction and second chain setup
	logic                 v_m1, v_m2, v_m3;
	logic [60:0]          prod_m1;
	logic [30:0]          mag_m2;
	logic [PW1-1:0]       p_m1, p_m2;
	logic signed [ZW-1:0] u_m1, u_m2, u_m3;
	logic signed [X2W-1:0] x2_m3, y2_m3;
	logic [61:0]          mag_sum;

	assign mag_sum = {1'b0, prod_m1} + (62'd1 << 29);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
			v_m3 <= 1'b0;
		end else if (en) begin
			v_m1 <= c1v[N];
			v_m2 <= v_m1;
			v_m3 <= v_m2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_m1 <= c1x[N][30:0] * KINV_Q30;
			p_m1    <= c1p[N];
			u_m1    <= c1z[N];
			mag_m2  <= mag_sum[60:30];
			p_m2    <= p_m1;
			u_m2    <= u_m1;
			x2_m3   <= X2W'(p_m2[FACE_W-1:0]) * X2W'(mag_m2);
			y2_m3   <= X2W'($signed({p_m2[PW1-1:FACE_W], {IN_SCALE{1'b0}}}));
			u_m3    <= u_m2;
		end
	end

	// second CORDIC chain: v = atan2(b*w, h*mag)
	logic                  c2v [0:N];
	logic signed [X2W-1:0] c2x [0:N];
	logic signed [X2W-1:0] c2y [0:N];
	logic signed [ZW-1:0]  c2z [0:N];
	logic [ZW-1:0]         c2p [0:N];

	assign c2v[0] = v_m3;
	assign c2x[0] = x2_m3;
	assign c2y[0] = y2_m3;
	assign c2z[0] = '0;
	assign c2p[0] = u_m3;

	for (genvar i = 0; i < N; i++) begin : g_c2
		ecfm_cordic_cell #(.XW(X2W), .PW(ZW), .STEP(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.prev_valid(c2v[i]), .prev_x(c2x[i]), .prev_y(c2y[i]),
			.prev_z(c2z[i]), .prev_pay(c2p[i]),
			.next_valid(c2v[i+1]), .next_x(c2x[i+1]), .next_y(c2y[i+1]),
			.next_z(c2z[i+1]), .next_pay(c2p[i+1])
		);
	end

	// wrap, bias and clamp
	logic signed [33:0] uw, vw, ub, vb;
	logic [31:0] bx;
	logic [30:0] by;

	always_comb begin
		uw = 34'($signed(c2p[N]));
		vw = 34'(c2z[N]);
		if (vw > 34'sd536870912) begin
			vw = vw - 34'sd1073741824;
			uw = uw + 34'sd1073741824;
		end else if (vw < -34'sd536870912) begin
			vw = vw + 34'sd1073741824;
			uw = uw + 34'sd1073741824;
		end
		if (uw > 34'sd1073741824) begin
			uw = uw - 34'sd2147483648;
		end else if (uw < -34'sd1073741824) begin
			uw = uw + 34'sd2147483648;
		end
		ub = uw + 34'sd1073741824;
		vb = vw + 34'sd536870912;
		if (ub < 0) begin
			bx = '0;
		end else if (ub > 34'sd2147483648) begin
			bx = 32'h8000_0000;
		end else begin
			bx = ub[31:0];
		end
		if (vb < 0) begin
			by = '0;
		end else if (vb > 34'sd1073741824) begin
			by = 31'h4000_0000;
		end else begin
			by = vb[30:0];
		end
	end

	logic        v_w1, v_p1;
	logic [31:0] bx_w1;
	logic [30:0] by_w1;
	logic [44:0] px_p1;
	logic [43:0] py_p1;
	logic [SRC_W-1:0] dx, dy;

	assign dx = (sw_q == '0) ? '0 : sw_q - SRC_W'(1);
	assign dy = (sh_q == '0) ? '0 : sh_q - SRC_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_w1      <= 1'b0;
			v_p1      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_w1      <= c2v[N];
			v_p1      <= v_w1;
			out_valid <= v_p1;
		end
	end

	// round, shift, saturate
	logic [45:0] rx, ry;
	logic [63:0] sx, sy;

	always_comb begin
		rx = ({1'b0, px_p1} + (46'd1 << (SHX - 1))) >> SHX;
		ry = ({2'b0, py_p1} + (46'd1 << (SHY - 1))) >> SHY;
		sx = (64'(rx) > LIM) ? LIM : 64'(rx);
		sy = (64'(ry) > LIM) ? LIM : 64'(ry);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bx_w1    <= bx;
			by_w1    <= by;
			px_p1    <= bx_w1 * dx;
			py_p1    <= by_w1 * dy;
			source_x <= sx[OUT_W-1:0];
			source_y <= sy[OUT_W-1:0];
		end
	end

endmodule
`default_nettype wire
